// ===== hw/rtl/gbb_pkg.sv =====
// ============================================================================
// gbb_pkg
// Shared types, codes and constants of the bitmap glyph blitter.
// ============================================================================
`default_nettype none

package gbb_pkg;

    // Default sizes of the glyph store.
    localparam int MAX_GLYPH_W = 8;
    localparam int MAX_GLYPH_H = 16;
    localparam int NUM_CODES   = 256;

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int CODE_W    = 8;
    localparam int ROW_W     = 4;
    localparam int PIX_W     = 64;
    localparam int GW_W      = 4;
    localparam int POS_W     = 16;
    localparam int X_W       = 24;
    localparam int Y_W       = 17;
    localparam int MASK_W    = 8;
    localparam int HEIGHT_W  = 5;
    localparam int TRANS_W   = 8;
    localparam int COUNT_W   = 9;
    localparam int FRAME_W   = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int DELTA_W   = 5;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_LOAD_ROW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_WIDTH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BEGIN     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DRAW      = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

    // Configuration reset values.
    localparam logic [HEIGHT_W-1:0] RST_GLYPH_HEIGHT = 5'd8;
    localparam logic [TRANS_W-1:0]  RST_TRANSPARENT  = 8'd0;
    localparam logic [COUNT_W-1:0]  RST_CHAR_COUNT   = 9'd0;
    localparam logic [FRAME_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [FRAME_W-1:0]  RST_FRAME_HEIGHT = 13'd480;

    // Pen arithmetic.
    localparam logic [DELTA_W-1:0] BAD_CODE_ADVANCE = 5'd4;
    localparam logic [DELTA_W-1:0] GLYPH_GAP        = 5'd1;
    localparam logic [X_W-1:0]     PEN_MAX          = 24'h7F_FFFF;

    // Rows per character never exceed this count.
    localparam int ROWS_OUT_MAX = 16;

    typedef struct packed {
        logic [HEIGHT_W-1:0] glyph_height;
        logic [TRANS_W-1:0]  transparent_index;
        logic [COUNT_W-1:0]  char_count;
        logic [FRAME_W-1:0]  frame_width;
        logic [FRAME_W-1:0]  frame_height;
    } cfg_t;

    typedef struct packed {
        logic              row_we;
        logic              wid_we;
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [GW_W-1:0]   width;
    } store_wr_t;

    typedef struct packed {
        logic              wid_re;
        logic              row_re;
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
    } store_rd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gbb_ram.sv =====
// ============================================================================
// gbb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
`default_nettype none

module gbb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gbb_cfg.sv =====
// ============================================================================
// gbb_cfg
// Configuration register file of the glyph blitter.
// ============================================================================
`default_nettype none

module gbb_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gbb_pkg::CFG_DAT_W-1:0]  cfg_data,
    output gbb_pkg::cfg_t                       cfg
);

    gbb_pkg::cfg_t cfg_reg;
    gbb_pkg::cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                gbb_pkg::CFG_GLYPH_HEIGHT:
                    cfg_next.glyph_height = cfg_data[gbb_pkg::HEIGHT_W-1:0];
                gbb_pkg::CFG_TRANSPARENT:
                    cfg_next.transparent_index = cfg_data[gbb_pkg::TRANS_W-1:0];
                gbb_pkg::CFG_CHAR_COUNT:
                    cfg_next.char_count = cfg_data[gbb_pkg::COUNT_W-1:0];
                gbb_pkg::CFG_FRAME_WIDTH:
                    cfg_next.frame_width = cfg_data[gbb_pkg::FRAME_W-1:0];
                gbb_pkg::CFG_FRAME_HEIGHT:
                    cfg_next.frame_height = cfg_data[gbb_pkg::FRAME_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_height      <= gbb_pkg::RST_GLYPH_HEIGHT;
            cfg_reg.transparent_index <= gbb_pkg::RST_TRANSPARENT;
            cfg_reg.char_count        <= gbb_pkg::RST_CHAR_COUNT;
            cfg_reg.frame_width       <= gbb_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height      <= gbb_pkg::RST_FRAME_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gbb_store.sv =====
// ============================================================================
// gbb_store
// Glyph store: one RAM of pixel rows and one RAM of glyph widths.
// ============================================================================
`default_nettype none

module gbb_store #(
    parameter int MAX_GLYPH_W = gbb_pkg::MAX_GLYPH_W,
    parameter int MAX_GLYPH_H = gbb_pkg::MAX_GLYPH_H,
    parameter int NUM_CODES   = gbb_pkg::NUM_CODES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire gbb_pkg::store_wr_t          wr,
    input  wire logic [gbb_pkg::PIX_W-1:0]   wr_pixels,
    input  wire gbb_pkg::store_rd_t          rd,
    output logic      [gbb_pkg::GW_W-1:0]    rd_width,
    output logic      [gbb_pkg::PIX_W-1:0]   rd_pixels
);

    localparam int ROW_DEPTH = NUM_CODES * MAX_GLYPH_H;
    localparam int ROW_AW    = $clog2(ROW_DEPTH);
    localparam int CODE_AW   = $clog2(NUM_CODES);

    logic                      wr_code_ok;
    logic                      wr_row_ok;
    logic                      rd_code_ok;
    logic [ROW_AW-1:0]         row_wr_addr;
    logic [ROW_AW-1:0]         row_rd_addr;
    logic [gbb_pkg::GW_W-1:0]  wid_sat;
    logic [gbb_pkg::GW_W-1:0]  wid_data;
    logic [NUM_CODES-1:0]      wid_valid_reg;
    logic [NUM_CODES-1:0]      wid_valid_next;
    logic                      wid_hit_reg;

    // Range checks and row addresses (code times rows per glyph plus row).
    assign wr_code_ok  = {1'b0, wr.code} < gbb_pkg::COUNT_W'(NUM_CODES);
    assign rd_code_ok  = {1'b0, rd.code} < gbb_pkg::COUNT_W'(NUM_CODES);
    assign wr_row_ok   = 6'(wr.row) < 6'(MAX_GLYPH_H);
    assign row_wr_addr = ROW_AW'(int'(wr.code) * MAX_GLYPH_H + int'(wr.row));
    assign row_rd_addr = ROW_AW'(int'(rd.code) * MAX_GLYPH_H + int'(rd.row));

    // Widths saturate at the widest glyph.
    assign wid_sat = (wr.width > gbb_pkg::GW_W'(MAX_GLYPH_W))
                   ? gbb_pkg::GW_W'(MAX_GLYPH_W) : wr.width;

    gbb_ram #(
        .DATA_W (gbb_pkg::PIX_W),
        .DEPTH  (ROW_DEPTH)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr.row_we && wr_code_ok && wr_row_ok),
        .wr_addr (row_wr_addr),
        .wr_data (wr_pixels),
        .rd_en   (rd.row_re),
        .rd_addr (row_rd_addr),
        .rd_data (rd_pixels)
    );

    gbb_ram #(
        .DATA_W (gbb_pkg::GW_W),
        .DEPTH  (NUM_CODES)
    ) u_wid_ram (
        .clk     (clk),
        .wr_en   (wr.wid_we && wr_code_ok),
        .wr_addr (wr.code[CODE_AW-1:0]),
        .wr_data (wid_sat),
        .rd_en   (rd.wid_re),
        .rd_addr (rd.code[CODE_AW-1:0]),
        .rd_data (wid_data)
    );

    // Per-code written flags; an unwritten width reads as zero.
    always_comb
    begin
        wid_valid_next = wid_valid_reg;
        if (wr.wid_we && wr_code_ok)
        begin
            wid_valid_next[wr.code[CODE_AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wid_valid_reg <= '0;
            wid_hit_reg   <= 1'b0;
        end
        else
        begin
            wid_valid_reg <= wid_valid_next;
            if (rd.wid_re)
            begin
                wid_hit_reg <= rd_code_ok && wid_valid_reg[rd.code[CODE_AW-1:0]];
            end
        end
    end

    assign rd_width = wid_hit_reg ? wid_data : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/gbb_seq.sv =====
// ============================================================================
// gbb_seq
// Command sequencer: pen state, glyph row streaming and output register.
// ============================================================================
`default_nettype none

module gbb_seq #(
    parameter int MAX_GLYPH_H = gbb_pkg::MAX_GLYPH_H,
    parameter int NUM_CODES   = gbb_pkg::NUM_CODES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gbb_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [gbb_pkg::CMD_W-1:0]     command,
    input  wire logic [gbb_pkg::CODE_W-1:0]    glyph_code,
    input  wire logic [gbb_pkg::ROW_W-1:0]     glyph_row,
    input  wire logic [gbb_pkg::GW_W-1:0]      glyph_width,
    input  wire logic signed [gbb_pkg::POS_W-1:0] start_x,
    input  wire logic signed [gbb_pkg::POS_W-1:0] start_y,
    output gbb_pkg::store_wr_t                 wr,
    output gbb_pkg::store_rd_t                 rd,
    input  wire logic [gbb_pkg::GW_W-1:0]      rd_width,
    input  wire logic [gbb_pkg::PIX_W-1:0]     rd_pixels,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [gbb_pkg::X_W-1:0]     row_x,
    output logic signed [gbb_pkg::Y_W-1:0]     row_y,
    output logic      [gbb_pkg::PIX_W-1:0]     pixel_bytes,
    output logic      [gbb_pkg::MASK_W-1:0]    write_mask,
    output logic                               last_row,
    output logic      [gbb_pkg::X_W-1:0]       advance_total
);

    localparam int ROW_CAP = (MAX_GLYPH_H < gbb_pkg::ROWS_OUT_MAX)
                           ? MAX_GLYPH_H : gbb_pkg::ROWS_OUT_MAX;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WIDTH = 2'd1;
    localparam logic [1:0] S_EMPTY = 2'd2;
    localparam logic [1:0] S_ROWS  = 2'd3;

    localparam int HW = gbb_pkg::HEIGHT_W;
    localparam int XW = gbb_pkg::X_W;
    localparam int PW = gbb_pkg::POS_W;
    localparam int MW = gbb_pkg::MASK_W;

    // Control state.
    logic [1:0]        state_reg, state_next;
    logic signed [XW-1:0] pen_reg, pen_next;
    logic [PW-1:0]     origin_x_reg, origin_x_next;
    logic [PW-1:0]     origin_y_reg, origin_y_next;
    logic [HW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [gbb_pkg::ROW_W-1:0] em_cnt_reg, em_cnt_next;
    logic              dv_reg, dv_next;
    logic              out_valid_reg, out_valid_next;

    // Per-character payload.
    logic [gbb_pkg::CODE_W-1:0] code_reg;
    logic [XW-1:0]     start_reg;
    logic [XW-1:0]     adv_reg;
    logic [MW-1:0]     colmask_reg;
    logic [HW-1:0]     rows_reg;

    // Output payload.
    logic [XW-1:0]     row_x_reg;
    logic [gbb_pkg::Y_W-1:0] row_y_reg;
    logic [gbb_pkg::PIX_W-1:0] pix_reg;
    logic [MW-1:0]     mask_reg;
    logic              last_reg;
    logic [XW-1:0]     adv_out_reg;

    // Combinational terms.
    logic                        in_acc;
    logic [gbb_pkg::COUNT_W-1:0] limit;
    logic                        bad_code;
    logic [gbb_pkg::DELTA_W-1:0] delta;
    logic [XW:0]                 pen_sum;
    logic [XW-1:0]               pen_sat;
    logic [XW-1:0]               adv_w;
    logic [HW-1:0]               rows_w;
    logic [MW-1:0]               colmask_w;
    logic [XW:0]                 col_x;
    logic                        out_free;
    logic                        row_load;
    logic                        empty_load;
    logic                        issue;
    logic                        is_last;
    logic [gbb_pkg::Y_W-1:0]     y_w;
    logic                        y_in;
    logic [MW-1:0]               mask_w;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;

    // Store write requests come straight from accepted load commands.
    always_comb
    begin
        wr.row_we = in_acc && (command == gbb_pkg::CMD_LOAD_ROW);
        wr.wid_we = in_acc && (command == gbb_pkg::CMD_SET_WIDTH);
        wr.code   = glyph_code;
        wr.row    = glyph_row;
        wr.width  = glyph_width;
    end

    // Store read requests: width at draw accept, then one row per cycle while the output is free.
    always_comb
    begin
        rd.wid_re = in_acc && (command == gbb_pkg::CMD_DRAW);
        rd.row_re = issue;
        rd.code   = (state_reg == S_IDLE) ? glyph_code : code_reg;
        rd.row    = rd_cnt_reg[gbb_pkg::ROW_W-1:0];
    end

    // Width lookup stage: code check, pen advance and column clip mask.
    always_comb
    begin
        limit    = (cfg.char_count < gbb_pkg::COUNT_W'(NUM_CODES))
                 ? cfg.char_count : gbb_pkg::COUNT_W'(NUM_CODES);
        bad_code = {1'b0, code_reg} >= limit;
        delta    = bad_code ? gbb_pkg::BAD_CODE_ADVANCE
                            : gbb_pkg::DELTA_W'(rd_width) + gbb_pkg::GLYPH_GAP;
        pen_sum  = {pen_reg[XW-1], pen_reg} + (XW+1)'(delta);
        pen_sat  = (!pen_sum[XW] && pen_sum[XW-1]) ? gbb_pkg::PEN_MAX : pen_sum[XW-1:0];
        adv_w    = pen_sat - {{(XW-PW){origin_x_reg[PW-1]}}, origin_x_reg};
        rows_w   = (cfg.glyph_height > HW'(ROW_CAP)) ? HW'(ROW_CAP) : cfg.glyph_height;
        col_x    = '0;
        for (int c = 0; c < MW; c++)
        begin
            col_x        = {pen_reg[XW-1], pen_reg} + (XW+1)'(c);
            colmask_w[c] = (gbb_pkg::GW_W'(c) < rd_width) && !col_x[XW]
                        && (col_x < (XW+1)'(cfg.frame_width));
        end
    end

    // Row stage: vertical clip and transparency per column.
    always_comb
    begin
        y_w  = {origin_y_reg[PW-1], origin_y_reg} + gbb_pkg::Y_W'(em_cnt_reg);
        y_in = !y_w[gbb_pkg::Y_W-1]
            && (y_w[PW-1:0] < PW'(cfg.frame_height));
        for (int c = 0; c < MW; c++)
        begin
            mask_w[c] = colmask_reg[c] && y_in
                     && (rd_pixels[8*c +: 8] != cfg.transparent_index);
        end
    end

    // Output handshake and row read pacing.
    assign out_free   = !out_valid_reg || out_ready;
    assign row_load   = (state_reg == S_ROWS) && dv_reg && out_free;
    assign empty_load = (state_reg == S_EMPTY) && out_free;
    assign issue      = (state_reg == S_ROWS) && (rd_cnt_reg < rows_reg)
                     && (!dv_reg || row_load);
    assign is_last    = ({1'b0, em_cnt_reg} == (rows_reg - HW'(1)));

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        pen_next       = pen_reg;
        origin_x_next  = origin_x_reg;
        origin_y_next  = origin_y_reg;
        rd_cnt_next    = rd_cnt_reg;
        em_cnt_next    = em_cnt_reg;
        dv_next        = dv_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (row_load || empty_load)
        begin
            out_valid_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (command == gbb_pkg::CMD_BEGIN))
                begin
                    origin_x_next = start_x;
                    origin_y_next = start_y;
                    pen_next      = {{(XW-PW){start_x[PW-1]}}, start_x};
                end
                if (in_acc && (command == gbb_pkg::CMD_DRAW))
                begin
                    state_next = S_WIDTH;
                end
            end
            S_WIDTH:
            begin
                pen_next    = pen_sat;
                rd_cnt_next = '0;
                em_cnt_next = '0;
                dv_next     = 1'b0;
                state_next  = (bad_code || (rows_w == '0)) ? S_EMPTY : S_ROWS;
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROWS:
            begin
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + HW'(1);
                    dv_next     = 1'b1;
                end
                else if (row_load)
                begin
                    dv_next = 1'b0;
                end
                if (row_load)
                begin
                    em_cnt_next = em_cnt_reg + gbb_pkg::ROW_W'(1);
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pen_reg       <= '0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            rd_cnt_reg    <= '0;
            em_cnt_reg    <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pen_reg       <= pen_next;
            origin_x_reg  <= origin_x_next;
            origin_y_reg  <= origin_y_next;
            rd_cnt_reg    <= rd_cnt_next;
            em_cnt_reg    <= em_cnt_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            code_reg <= glyph_code;
        end
        if (state_reg == S_WIDTH)
        begin
            start_reg   <= pen_reg;
            adv_reg     <= adv_w;
            colmask_reg <= colmask_w;
            rows_reg    <= rows_w;
        end
        if (row_load)
        begin
            row_x_reg   <= start_reg;
            row_y_reg   <= y_w;
            pix_reg     <= rd_pixels;
            mask_reg    <= mask_w;
            last_reg    <= is_last;
            adv_out_reg <= adv_reg;
        end
        else if (empty_load)
        begin
            row_x_reg   <= start_reg;
            row_y_reg   <= {origin_y_reg[PW-1], origin_y_reg};
            pix_reg     <= '0;
            mask_reg    <= '0;
            last_reg    <= 1'b1;
            adv_out_reg <= adv_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign row_x         = row_x_reg;
    assign row_y         = row_y_reg;
    assign pixel_bytes   = pix_reg;
    assign write_mask    = mask_reg;
    assign last_row      = last_reg;
    assign advance_total = adv_out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_glyph_blitter_top.sv =====
// ============================================================================
// bitmap_glyph_blitter_top
// Text renderer that turns character requests into masked glyph row writes.
// ============================================================================
// Usage: requests arrive on the in_* channel. Load-row and set-width requests
// fill the glyph store, a begin request places the pen, and a draw request
// produces one result per glyph row on the out_* channel: the row position,
// its eight pixels and a byte write mask, with last_row on the final one.
// Configuration registers are written through the cfg_* channel, which is
// always ready; write them only while the block is idle.
// Sequence: load, width and begin requests are taken while idle. A draw is
// accepted, then the width lookup and pen update run, then rows (glyph_height
// capped at 16) are read at one row per cycle while the output is free, out
// of the single read port of the row RAM, whose read is registered. A code
// outside the font, or a zero glyph height, gives one empty result.
// Stalls: the output register holds a result until out_ready; row reads
// pause behind it and no new request is accepted until the draw finishes.
// Reset: pen and origin return to zero, widths read as zero, registers take
// their defaults; the row store holds no defined content until loaded.
// ============================================================================
`default_nettype none

module bitmap_glyph_blitter_top #(
    parameter int MAX_GLYPH_W = gbb_pkg::MAX_GLYPH_W,
    parameter int MAX_GLYPH_H = gbb_pkg::MAX_GLYPH_H,
    parameter int NUM_CODES   = gbb_pkg::NUM_CODES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gbb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gbb_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [gbb_pkg::CMD_W-1:0]         command,
    input  wire logic [gbb_pkg::CODE_W-1:0]        glyph_code,
    input  wire logic [gbb_pkg::ROW_W-1:0]         glyph_row,
    input  wire logic [gbb_pkg::PIX_W-1:0]         row_pixels,
    input  wire logic [gbb_pkg::GW_W-1:0]          glyph_width,
    input  wire logic signed [gbb_pkg::POS_W-1:0]  start_x,
    input  wire logic signed [gbb_pkg::POS_W-1:0]  start_y,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [gbb_pkg::X_W-1:0]         row_x,
    output logic signed [gbb_pkg::Y_W-1:0]         row_y,
    output logic      [gbb_pkg::PIX_W-1:0]         pixel_bytes,
    output logic      [gbb_pkg::MASK_W-1:0]        write_mask,
    output logic                                   last_row,
    output logic      [gbb_pkg::X_W-1:0]           advance_total
);

    gbb_pkg::cfg_t      cfg;
    gbb_pkg::store_wr_t st_wr;
    gbb_pkg::store_rd_t st_rd;
    logic [gbb_pkg::GW_W-1:0]  st_width;
    logic [gbb_pkg::PIX_W-1:0] st_pixels;

    // Configuration registers.
    gbb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Glyph row and width memories.
    gbb_store #(
        .MAX_GLYPH_W (MAX_GLYPH_W),
        .MAX_GLYPH_H (MAX_GLYPH_H),
        .NUM_CODES   (NUM_CODES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (st_wr),
        .wr_pixels (row_pixels),
        .rd        (st_rd),
        .rd_width  (st_width),
        .rd_pixels (st_pixels)
    );

    // Request sequencer and result register.
    gbb_seq #(
        .MAX_GLYPH_H (MAX_GLYPH_H),
        .NUM_CODES   (NUM_CODES)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .glyph_code    (glyph_code),
        .glyph_row     (glyph_row),
        .glyph_width   (glyph_width),
        .start_x       (start_x),
        .start_y       (start_y),
        .wr            (st_wr),
        .rd            (st_rd),
        .rd_width      (st_width),
        .rd_pixels     (st_pixels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .row_x         (row_x),
        .row_y         (row_y),
        .pixel_bytes   (pixel_bytes),
        .write_mask    (write_mask),
        .last_row      (last_row),
        .advance_total (advance_total)
    );

endmodule

`default_nettype wire

// ===== sim/bitmap_glyph_blitter_top_tb.sv =====
// ============================================================================
// bitmap_glyph_blitter_top_tb
// Self-checking bench for the glyph blitter. A scoreboard object keeps its own
// copy of the glyph store, pen and registers, and predicts the row writes of
// every accepted request. Results are checked in order, field by field. Both
// channels see random gaps and stalls across several register settings.
// ============================================================================
`timescale 1ns / 1ps

module bitmap_glyph_blitter_top_tb;
    import gbb_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_REQUESTS = 18;
    localparam int FONT_SIZE      = 6;
    localparam int STORE_DEPTH    = NUM_CODES * MAX_GLYPH_H;

    // One request on the input channel.
    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [CODE_W-1:0]       code;
        logic [ROW_W-1:0]        row;
        logic [PIX_W-1:0]        pixels;
        logic [GW_W-1:0]         width;
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
    } glyph_req_t;

    // One masked row write on the output channel.
    typedef struct {
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [PIX_W-1:0]  pixels;
        logic [MASK_W-1:0] mask;
        logic              last_flag;
        logic [X_W-1:0]    advance;
    } row_write_t;

    // ------------------------------------------------------------------------
    // Scoreboard: glyph store, pen and registers, plus the queue of row writes
    // still owed by the block.
    // ------------------------------------------------------------------------
    class glyph_row_scoreboard;
        bit [PIX_W-1:0]       row_store [STORE_DEPTH];
        bit [STORE_DEPTH-1:0] row_loaded;
        bit [GW_W-1:0]        width_store [NUM_CODES];
        int pen_x;
        int origin_x;
        int origin_y;
        int glyph_height;
        int transparent_index;
        int char_count;
        int frame_width;
        int frame_height;
        row_write_t owed_rows [$];
        int errors;

        function new();
            foreach (width_store[i]) width_store[i] = '0;
            row_loaded        = '0;
            pen_x             = 0;
            origin_x          = 0;
            origin_y          = 0;
            glyph_height      = int'(RST_GLYPH_HEIGHT);
            transparent_index = int'(RST_TRANSPARENT);
            char_count        = int'(RST_CHAR_COUNT);
            frame_width       = int'(RST_FRAME_WIDTH);
            frame_height      = int'(RST_FRAME_HEIGHT);
            errors            = 0;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
            case (index)
                CFG_GLYPH_HEIGHT: glyph_height      = int'(data[HEIGHT_W-1:0]);
                CFG_TRANSPARENT:  transparent_index = int'(data[TRANS_W-1:0]);
                CFG_CHAR_COUNT:   char_count        = int'(data[COUNT_W-1:0]);
                CFG_FRAME_WIDTH:  frame_width       = int'(data[FRAME_W-1:0]);
                CFG_FRAME_HEIGHT: frame_height      = int'(data[FRAME_W-1:0]);
                default: ;
            endcase
        endfunction

        function int font_limit();
            return (char_count < NUM_CODES) ? char_count : NUM_CODES;
        endfunction

        function int rows_per_glyph();
            int rows;
            rows = glyph_height;
            if (rows > MAX_GLYPH_H) rows = MAX_GLYPH_H;
            if (rows > ROWS_OUT_MAX) rows = ROWS_OUT_MAX;
            return rows;
        endfunction

        // A draw must never read a glyph row that was not loaded.
        function bit draw_is_safe(logic [CODE_W-1:0] code);
            int rows;
            if (int'(code) >= font_limit()) return 1'b1;
            rows = rows_per_glyph();
            for (int r = 0; r < rows; r++)
                if (!row_loaded[int'(code) * MAX_GLYPH_H + r]) return 1'b0;
            return 1'b1;
        endfunction

        function int pen_step(int p, int d);
            longint s;
            s = longint'(p) + longint'(d);
            if (s > longint'(PEN_MAX)) s = longint'(PEN_MAX);
            if (s < -longint'(PEN_MAX) - 1) s = -longint'(PEN_MAX) - 1;
            return int'(s);
        endfunction

        function void owe_row(int x, int y, logic [PIX_W-1:0] pixels,
                              logic [MASK_W-1:0] mask, logic last_flag);
            row_write_t w;
            w.x         = X_W'(x);
            w.y         = Y_W'(y);
            w.pixels    = pixels;
            w.mask      = mask;
            w.last_flag = last_flag;
            w.advance   = X_W'(pen_x - origin_x);
            owed_rows.push_back(w);
        endfunction

        // Update the state for an accepted request and queue its row writes.
        function void note_request(glyph_req_t q);
            int start;
            int rows;
            int w;
            int py;
            int px;
            int slot;
            logic [PIX_W-1:0]  pix;
            logic [MASK_W-1:0] mask;
            case (q.cmd)
                CMD_LOAD_ROW:
                begin
                    if (int'(q.row) < MAX_GLYPH_H)
                    begin
                        slot = int'(q.code) * MAX_GLYPH_H + int'(q.row);
                        row_store[slot]  = q.pixels;
                        row_loaded[slot] = 1'b1;
                    end
                end
                CMD_SET_WIDTH:
                begin
                    width_store[q.code] = (int'(q.width) > MAX_GLYPH_W)
                                          ? GW_W'(MAX_GLYPH_W) : q.width;
                end
                CMD_BEGIN:
                begin
                    origin_x = int'(q.sx);
                    origin_y = int'(q.sy);
                    pen_x    = origin_x;
                end
                default:
                begin
                    start = pen_x;
                    if (int'(q.code) >= font_limit())
                    begin
                        // Code outside the font: one empty write, fixed advance.
                        pen_x = pen_step(pen_x, int'(BAD_CODE_ADVANCE));
                        owe_row(start, origin_y, '0, '0, 1'b1);
                    end
                    else
                    begin
                        w     = int'(width_store[q.code]);
                        pen_x = pen_step(pen_x, w + int'(GLYPH_GAP));
                        rows  = rows_per_glyph();
                        if (rows == 0)
                            owe_row(start, origin_y, '0, '0, 1'b1);
                        for (int r = 0; r < rows; r++)
                        begin
                            pix  = row_store[int'(q.code) * MAX_GLYPH_H + r];
                            py   = origin_y + r;
                            mask = '0;
                            if (py >= 0 && py < frame_height)
                            begin
                                for (int c = 0; c < w; c++)
                                begin
                                    px = start + c;
                                    if (int'(pix[8*c +: 8]) != transparent_index &&
                                        px >= 0 && px < frame_width)
                                        mask[c] = 1'b1;
                                end
                            end
                            owe_row(start, py, pix, mask, r == rows - 1);
                        end
                    end
                end
            endcase
        endfunction

        function int pending();
            return owed_rows.size();
        endfunction

        task check_result(row_write_t got);
            row_write_t exp_row;
            if (owed_rows.size() == 0)
            begin
                report("row write with no request outstanding");
                return;
            end
            exp_row = owed_rows.pop_front();
            if (got.x !== exp_row.x)
                report($sformatf("row_x got %0d expected %0d",
                                 $signed(got.x), $signed(exp_row.x)));
            if (got.y !== exp_row.y)
                report($sformatf("row_y got %0d expected %0d",
                                 $signed(got.y), $signed(exp_row.y)));
            if (got.pixels !== exp_row.pixels)
                report($sformatf("pixel_bytes got %h expected %h",
                                 got.pixels, exp_row.pixels));
            if (got.mask !== exp_row.mask)
                report($sformatf("write_mask got %b expected %b", got.mask, exp_row.mask));
            if (got.last_flag !== exp_row.last_flag)
                report($sformatf("last_row got %b expected %b",
                                 got.last_flag, exp_row.last_flag));
            if (got.advance !== exp_row.advance)
                report($sformatf("advance_total got %0d expected %0d",
                                 got.advance, exp_row.advance));
        endtask
    endclass

    // DUT ports.
    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DAT_W-1:0]    cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [CMD_W-1:0]        command;
    logic [CODE_W-1:0]       glyph_code;
    logic [ROW_W-1:0]        glyph_row;
    logic [PIX_W-1:0]        row_pixels;
    logic [GW_W-1:0]         glyph_width;
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [X_W-1:0]   row_x;
    logic signed [Y_W-1:0]   row_y;
    logic [PIX_W-1:0]        pixel_bytes;
    logic [MASK_W-1:0]       write_mask;
    logic                    last_row;
    logic [X_W-1:0]          advance_total;

    glyph_row_scoreboard sb;
    row_write_t          seen_row;
    logic [CODE_W-1:0]   font_codes [FONT_SIZE];
    int                  font_widths [FONT_SIZE];
    int                  send_calm;
    int                  cycle_count;

    // Register settings per phase; phase zero keeps the reset values.
    int phase_height [NUM_PHASES] = '{8, 16, 0, 31, 1, 8};
    int phase_trans  [NUM_PHASES] = '{0, 0, 255, 90, 0, 255};
    int phase_count  [NUM_PHASES] = '{0, 256, 3, 511, 128, 200};
    int phase_fwidth [NUM_PHASES] = '{640, 640, 8191, 1, 4096, 64};
    int phase_fheight[NUM_PHASES] = '{480, 480, 8191, 1, 4096, 40};

    bitmap_glyph_blitter_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .glyph_code    (glyph_code),
        .glyph_row     (glyph_row),
        .row_pixels    (row_pixels),
        .glyph_width   (glyph_width),
        .start_x       (start_x),
        .start_y       (start_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .row_x         (row_x),
        .row_y         (row_y),
        .pixel_bytes   (pixel_bytes),
        .write_mask    (write_mask),
        .last_row      (last_row),
        .advance_total (advance_total)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Pixel rows favor the values used as transparent index.
    function automatic logic [PIX_W-1:0] random_pixels();
        logic [PIX_W-1:0] pix;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 5))
                0:       pix[8*i +: 8] = 8'h00;
                1:       pix[8*i +: 8] = 8'hFF;
                2:       pix[8*i +: 8] = 8'h5A;
                default: pix[8*i +: 8] = 8'($urandom);
            endcase
        end
        return pix;
    endfunction

    // Mostly near the frame so that clipping edges are hit, sometimes anywhere.
    function automatic logic signed [POS_W-1:0] origin_coord(int span);
        if ($urandom_range(0, 9) < 3)
            return POS_W'($urandom);
        return POS_W'(int'($urandom_range(0, span + 20)) - 10);
    endfunction

    function automatic glyph_req_t random_request();
        glyph_req_t q;
        q.cmd    = CMD_W'($urandom_range(0, 3));
        q.code   = CODE_W'($urandom);
        q.row    = ROW_W'($urandom);
        q.pixels = random_pixels();
        q.width  = GW_W'($urandom);
        q.sx     = POS_W'($urandom);
        q.sy     = POS_W'($urandom);
        return q;
    endfunction

    // Draw codes: mostly loaded glyphs, some anywhere, some outside the font.
    function automatic logic [CODE_W-1:0] pick_draw_code();
        logic [CODE_W-1:0] code;
        int                lim;
        lim = sb.font_limit();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: code = font_codes[$urandom_range(0, FONT_SIZE - 1)];
            6, 7:             code = CODE_W'($urandom);
            default:          code = (lim < NUM_CODES) ? CODE_W'($urandom_range(lim, NUM_CODES - 1))
                                                       : CODE_W'($urandom);
        endcase
        if (!sb.draw_is_safe(code))
            code = font_codes[$urandom_range(0, FONT_SIZE - 1)];
        return code;
    endfunction

    // Drive one request, wait for its handshake, then idle for a random gap.
    task automatic send_request(glyph_req_t q);
        int gap;
        int r;
        @(negedge clk);
        in_valid    <= 1'b1;
        command     <= q.cmd;
        glyph_code  <= q.code;
        glyph_row   <= q.row;
        row_pixels  <= q.pixels;
        glyph_width <= q.width;
        start_x     <= q.sx;
        start_y     <= q.sy;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(q);
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                send_calm = $urandom_range(15, 40);
                gap = 0;
            end
            else if (r < 50) gap = 0;
            else if (r < 90) gap = $urandom_range(1, 3);
            else if (r < 97) gap = $urandom_range(4, 8);
            else gap = $urandom_range(12, 25);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic load_row(logic [CODE_W-1:0] code, int row, logic [PIX_W-1:0] pixels);
        glyph_req_t q;
        q        = random_request();
        q.cmd    = CMD_LOAD_ROW;
        q.code   = code;
        q.row    = ROW_W'(row);
        q.pixels = pixels;
        send_request(q);
    endtask

    task automatic set_width(logic [CODE_W-1:0] code, int width);
        glyph_req_t q;
        q       = random_request();
        q.cmd   = CMD_SET_WIDTH;
        q.code  = code;
        q.width = GW_W'(width);
        send_request(q);
    endtask

    task automatic begin_string(int x, int y);
        glyph_req_t q;
        q     = random_request();
        q.cmd = CMD_BEGIN;
        q.sx  = POS_W'(x);
        q.sy  = POS_W'(y);
        send_request(q);
    endtask

    task automatic draw_char(logic [CODE_W-1:0] code);
        glyph_req_t q;
        q      = random_request();
        q.cmd  = CMD_DRAW;
        q.code = code;
        send_request(q);
    endtask

    // Hold the sender off until every owed row write has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DAT_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_register(index, CFG_DAT_W'(value));
    endtask

    task automatic apply_settings(int p);
        write_register(CFG_GLYPH_HEIGHT, phase_height[p]);
        write_register(CFG_TRANSPARENT,  phase_trans[p]);
        write_register(CFG_CHAR_COUNT,   phase_count[p]);
        write_register(CFG_FRAME_WIDTH,  phase_fwidth[p]);
        write_register(CFG_FRAME_HEIGHT, phase_fheight[p]);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly strings of draws after a begin, glyph definitions,
    // and some loose requests of any kind.
    task automatic run_random(int budget);
        glyph_req_t        q;
        logic [CODE_W-1:0] code;
        int                sent;
        int                kind;
        int                n;
        sent = 0;
        while (sent < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                begin_string(origin_coord(sb.frame_width), origin_coord(sb.frame_height));
                sent++;
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    draw_char(pick_draw_code());
                    sent++;
                end
            end
            else if (kind < 80)
            begin
                code = CODE_W'($urandom);
                set_width(code, $urandom_range(0, 15));
                sent++;
                n = $urandom_range(1, MAX_GLYPH_H);
                for (int r = 0; r < n; r++)
                begin
                    load_row(code, r, random_pixels());
                    sent++;
                end
            end
            else
            begin
                q = random_request();
                if (q.cmd == CMD_DRAW)
                    q.code = pick_draw_code();
                send_request(q);
                sent++;
            end
        end
    endtask

    // Result side: random stalls, a few long ones, and stretches with none.
    initial
    begin
        int r;
        int sink_stall;
        int sink_calm;
        out_ready  = 1'b0;
        sink_stall = 0;
        sink_calm  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (sink_stall > 0)
            begin
                sink_stall--;
                out_ready <= 1'b0;
            end
            else if (sink_calm > 0)
            begin
                sink_calm--;
                out_ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4) sink_calm = $urandom_range(20, 60);
                else if (r < 25) sink_stall = $urandom_range(1, 3);
                else if (r < 28) sink_stall = $urandom_range(10, 30);
                out_ready <= (sink_stall == 0);
            end
        end
    end

    // Check every accepted row write.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_row.x         = row_x;
            seen_row.y         = row_y;
            seen_row.pixels    = pixel_bytes;
            seen_row.mask      = write_mask;
            seen_row.last_flag = last_row;
            seen_row.advance   = advance_total;
            sb.check_result(seen_row);
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence.
    initial
    begin
        sb          = new();
        font_codes  = '{8'd0, 8'd1, 8'd2, 8'd65, 8'd254, 8'd255};
        font_widths = '{8, 0, 3, 5, 15, 8};
        send_calm   = 0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        command     = CMD_LOAD_ROW;
        glyph_code  = '0;
        glyph_row   = '0;
        row_pixels  = '0;
        glyph_width = '0;
        start_x     = '0;
        start_y     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Build a small font, every row loaded, with blank and solid rows.
        for (int i = 0; i < FONT_SIZE; i++)
        begin
            set_width(font_codes[i], font_widths[i]);
            for (int r = 0; r < MAX_GLYPH_H; r++)
                load_row(font_codes[i], r, (r == 0) ? '0 : (r == 1) ? '1 : random_pixels());
        end

        // The character count is zero after reset, so every draw gives an empty write.
        draw_char(8'd0);
        draw_char(8'd255);
        run_random(PHASE_REQUESTS);

        for (int p = 1; p < NUM_PHASES; p++)
        begin
            drain_results();
            apply_settings(p);
            case (p)
                1:
                begin
                    // Clipping at every frame edge, zero and saturated widths.
                    begin_string(-4, -3);
                    draw_char(8'd0);
                    draw_char(8'd1);
                    begin_string(636, 476);
                    draw_char(8'd0);
                    draw_char(8'd254);
                    begin_string(-32768, -32768);
                    draw_char(8'd0);
                    begin_string(32767, 32767);
                    draw_char(8'd255);
                    begin_string(0, 0);
                    draw_char(8'd2);
                    draw_char(8'd65);
                end
                2:
                begin
                    // Zero glyph height, then codes past the font.
                    draw_char(8'd2);
                    draw_char(8'd3);
                    draw_char(8'd255);
                end
                3:
                begin
                    // Tall height clamps to the row limit; a one-pixel frame.
                    begin_string(0, 0);
                    draw_char(8'd0);
                    draw_char(8'd65);
                end
                default: ;
            endcase
            if (p == 1)
            begin
                run_random(PHASE_REQUESTS / 2);
                drain_results();
                run_random(PHASE_REQUESTS - PHASE_REQUESTS / 2);
            end
            else
            begin
                run_random(PHASE_REQUESTS);
            end
        end

        drain_results();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d row writes never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/gbb_pkg.sv
hw/rtl/gbb_ram.sv
hw/rtl/gbb_cfg.sv
hw/rtl/gbb_store.sv
hw/rtl/gbb_seq.sv
hw/rtl/bitmap_glyph_blitter_top.sv
sim/bitmap_glyph_blitter_top_tb.sv
